FILE: rtl/sewd_pkg.sv
// sewd_pkg: shared constants and lane control type for the sonar echo window detector
`default_nettype none

package sewd_pkg;

    // capture limits
    localparam int MAX_SAMPLES = 512;
    localparam int CHANNELS    = 4;
    localparam int MAX_PULSE   = 20;

    // fixed field widths
    localparam int SAMP_W  = 8;
    localparam int CFG_W   = 8;
    localparam int PLEN_W  = 5;
    localparam int OIDX_W  = 9;

    // derived widths
    localparam int CNT_W   = $clog2(MAX_SAMPLES) + 1;
    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int PTR_W   = $clog2(MAX_PULSE);
    localparam int PW      = $clog2(MAX_PULSE + 1);
    localparam int WSUM_W  = SAMP_W + PW;
    localparam int NSUM_W  = 2 * SAMP_W;
    localparam int DCNT_W  = $clog2(SAMP_W);

    localparam int IN_TDATA_W  = CHANNELS * SAMP_W;
    localparam int RES_W       = 1 + OIDX_W;
    localparam int OUT_TDATA_W = ((CHANNELS * RES_W + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [1:0] REG_THR_MULT  = 2'd1;
    localparam logic [1:0] REG_PULSE_LEN = 2'd2;

    localparam logic [CFG_W-1:0]  DEAD_ZONE_RST = 8'd16;
    localparam logic [CFG_W-1:0]  THR_MULT_RST  = 8'd3;
    localparam logic [PLEN_W-1:0] PULSE_LEN_RST = 5'd1;

    localparam logic [SAMP_W-1:0] THR_SAT = 8'd255;

    // per-beat control shared by all lanes
    typedef struct packed {
        logic               acc;
        logic               last;
        logic               eval_en;
        logic               noise_en;
        logic               sub_en;
        logic               div_start;
        logic               div_step;
        logic               do_mult;
        logic               do_scale;
        logic               n_ok;
        logic [PTR_W-1:0]   rd_ptr;
        logic [PTR_W-1:0]   wr_ptr;
        logic [IDX_W-1:0]   start_idx;
        logic [CFG_W-1:0]   dead_zone;
        logic [CFG_W-1:0]   thr_mult;
        logic [PW-1:0]      pulse;
    } t_lane_ctl;

endpackage

`default_nettype wire

FILE: rtl/sonar_echo_window_detector_top.sv
// sonar_echo_window_detector_top: four-lane boxcar echo detector with peak pick
//
// usage
// - slave stream: one beat per sample set, tdata holds four 8-bit receiver
//   samples (channel 0 lowest), tlast marks the final set of a capture
// - master stream: one beat per capture, sent for the beat carrying tlast,
//   with found and echo index for each receiver
// - config channel: index 0 dead zone, 1 threshold multiplier, 2 pulse length;
//   always ready, write only between captures
// - throughput: one sample beat per cycle, apart from a pause after the beat
//   that closes the dead zone, while each lane's shift-subtract divider works
//   out the noise floor and the threshold is scaled by the multiplier and then
//   by the pulse length
// - latency: the result beat is valid the cycle after the tlast beat
// - the result sits in an output register; further sample beats are taken
//   while it waits, but a tlast beat is held off until the slot is free
// - reset clears the sample count, all sums and the scaled thresholds and
//   restores the register defaults; the sample ring needs no clearing
// - samples past the capture limit are dropped, their tlast still closes
`default_nettype none

module sonar_echo_window_detector_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream: sample_ch0, sample_ch1, sample_ch2, sample_ch3
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [sewd_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  wire logic                                i_s_tlast,
    // master stream: found_ch0, echo_index_ch0, found_ch1, echo_index_ch1,
    // found_ch2, echo_index_ch2, found_ch3, echo_index_ch3
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [sewd_pkg::OUT_TDATA_W-1:0]         o_m_tdata,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [1:0]                          i_cfg_index,
    input  wire logic [sewd_pkg::CFG_W-1:0]          i_cfg_data
);

    // sequencer states
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_SCALE = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [sewd_pkg::DCNT_W-1:0]    r_dcnt;
    logic [sewd_pkg::CFG_W-1:0]     r_dead_zone;
    logic [sewd_pkg::CFG_W-1:0]     r_thr_mult;
    logic [sewd_pkg::PLEN_W-1:0]    r_pulse_len;
    logic [sewd_pkg::CNT_W-1:0]     r_cnt;
    logic [sewd_pkg::PTR_W-1:0]     r_wr_ptr;

    logic                           s_acc;
    logic                           active;
    logic [sewd_pkg::PW-1:0]        pulse;
    logic [sewd_pkg::CNT_W-1:0]     dz_ext, p_ext, dp, n_cnt;
    logic                           trig;
    logic [sewd_pkg::PTR_W:0]       rd_wide;
    sewd_pkg::t_lane_ctl            ctl;

    logic [sewd_pkg::CHANNELS-1:0]  lane_found;
    logic [sewd_pkg::OIDX_W-1:0]    lane_idx [sewd_pkg::CHANNELS];

    // ---- configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= sewd_pkg::DEAD_ZONE_RST;
            r_thr_mult  <= sewd_pkg::THR_MULT_RST;
            r_pulse_len <= sewd_pkg::PULSE_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sewd_pkg::REG_DEAD_ZONE: r_dead_zone <= i_cfg_data;
                sewd_pkg::REG_THR_MULT:  r_thr_mult  <= i_cfg_data;
                sewd_pkg::REG_PULSE_LEN: r_pulse_len <= i_cfg_data[sewd_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective window width, zero taken as one and clamped to the ring depth
    always_comb begin
        if (r_pulse_len == '0) begin
            pulse = sewd_pkg::PW'(1);
        end else if (sewd_pkg::PW'(r_pulse_len) > sewd_pkg::PW'(sewd_pkg::MAX_PULSE)) begin
            pulse = sewd_pkg::PW'(sewd_pkg::MAX_PULSE);
        end else begin
            pulse = sewd_pkg::PW'(r_pulse_len);
        end
    end

    // ---- beat decode
    assign o_s_tready = (r_state == ST_RUN) && (!o_m_tvalid || i_m_tready || !i_s_tlast);
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        dz_ext  = sewd_pkg::CNT_W'(r_dead_zone);
        p_ext   = sewd_pkg::CNT_W'(pulse);
        dp      = dz_ext + p_ext;
        active  = r_cnt < sewd_pkg::CNT_W'(sewd_pkg::MAX_SAMPLES);
        n_cnt   = active ? r_cnt + 1'b1 : r_cnt;
        trig    = active && (r_dead_zone != '0) && (r_cnt == dz_ext - 1'b1);
        rd_wide = (sewd_pkg::PW'(r_wr_ptr) >= pulse)
                  ? (sewd_pkg::PTR_W+1)'(r_wr_ptr) - (sewd_pkg::PTR_W+1)'(pulse)
                  : (sewd_pkg::PTR_W+1)'(r_wr_ptr) + (sewd_pkg::PTR_W+1)'(sewd_pkg::MAX_PULSE)
                    - (sewd_pkg::PTR_W+1)'(pulse);

        ctl.acc       = s_acc && active;
        ctl.last      = s_acc && i_s_tlast;
        ctl.eval_en   = active && (r_cnt >= dp);
        ctl.noise_en  = active && (r_cnt < dz_ext);
        ctl.sub_en    = active && (r_cnt >= p_ext);
        ctl.div_start = s_acc && trig && !i_s_tlast;
        ctl.div_step  = (r_state == ST_DIV);
        ctl.do_mult   = (r_state == ST_MUL);
        ctl.do_scale  = (r_state == ST_SCALE);
        ctl.n_ok      = n_cnt >= dp;
        ctl.rd_ptr    = rd_wide[sewd_pkg::PTR_W-1:0];
        ctl.wr_ptr    = r_wr_ptr;
        ctl.start_idx = sewd_pkg::IDX_W'(r_cnt - p_ext);
        ctl.dead_zone = r_dead_zone;
        ctl.thr_mult  = r_thr_mult;
        ctl.pulse     = pulse;
    end

    // ---- capture position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_wr_ptr <= '0;
        end else if (ctl.last) begin
            r_cnt    <= '0;
            r_wr_ptr <= '0;
        end else if (ctl.acc) begin
            r_cnt    <= n_cnt;
            r_wr_ptr <= (r_wr_ptr == sewd_pkg::PTR_W'(sewd_pkg::MAX_PULSE - 1))
                        ? '0 : r_wr_ptr + 1'b1;
        end
    end

    // ---- threshold sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN:   if (ctl.div_start) n_state = ST_DIV;
            ST_DIV:   if (r_dcnt == sewd_pkg::DCNT_W'(sewd_pkg::SAMP_W - 1)) n_state = ST_MUL;
            ST_MUL:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_RUN;
            default:  n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_dcnt  <= (r_state == ST_DIV) ? r_dcnt + 1'b1 : '0;
        end
    end

    // ---- lanes, one per receiver
    for (genvar ch = 0; ch < sewd_pkg::CHANNELS; ch++) begin : g_lane
        sewd_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_sample     (i_s_tdata[ch*sewd_pkg::SAMP_W +: sewd_pkg::SAMP_W]),
            .i_ctl        (ctl),
            .o_found      (lane_found[ch]),
            .o_echo_index (lane_idx[ch])
        );
    end

    // ---- result register
    sewd_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (ctl.last),
        .i_found      (lane_found),
        .i_echo_index (lane_idx),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_no_beat_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_s_tready)
        else $error("sample beat taken while threshold is being computed");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> (o_m_tvalid && (r_cnt == '0) && (r_wr_ptr == '0)))
        else $error("closing beat did not produce a result and clear the capture");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sewd_pkg::CNT_W'(sewd_pkg::MAX_SAMPLES))
        else $error("sample count past capture limit");

    a_ptr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr < sewd_pkg::PTR_W'(sewd_pkg::MAX_PULSE))
        else $error("ring pointer past ring depth");

    a_div_starts_on_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.div_start |=> (r_state == ST_DIV))
        else $error("divider did not start at end of dead zone");
`endif

endmodule

`default_nettype wire

FILE: rtl/sewd_lane.sv
// sewd_lane: per-receiver noise floor, sliding window sum and peak tracking
`default_nettype none

module sewd_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [sewd_pkg::SAMP_W-1:0]    i_sample,
    input  wire sewd_pkg::t_lane_ctl            i_ctl,
    output logic                                o_found,
    output logic [sewd_pkg::OIDX_W-1:0]         o_echo_index
);

    logic [sewd_pkg::SAMP_W-1:0]  r_ring [sewd_pkg::MAX_PULSE];
    logic [sewd_pkg::WSUM_W-1:0]  r_wsum, n_wsum;
    logic [sewd_pkg::WSUM_W-1:0]  r_best, n_best;
    logic [sewd_pkg::IDX_W-1:0]   r_bstart, n_bstart;
    logic [sewd_pkg::NSUM_W-1:0]  r_noise, n_noise;
    logic [sewd_pkg::WSUM_W-1:0]  r_thr_p;
    logic [sewd_pkg::SAMP_W-1:0]  r_rem;
    logic [sewd_pkg::SAMP_W-1:0]  r_dvd_lo;
    logic [sewd_pkg::SAMP_W-1:0]  r_quot;
    logic [sewd_pkg::SAMP_W-1:0]  r_thr;
    logic [sewd_pkg::SAMP_W:0]    div_tmp;
    logic                         div_ge;
    logic [2*sewd_pkg::SAMP_W-1:0] thr_prod;
    logic [sewd_pkg::SAMP_W-1:0]  old_samp;
    logic                         upd;
    logic [sewd_pkg::OIDX_W-1:0]  base_idx;

    // window bookkeeping for this beat
    always_comb begin
        old_samp = i_ctl.sub_en ? r_ring[i_ctl.rd_ptr] : '0;
        n_wsum   = r_wsum - sewd_pkg::WSUM_W'(old_samp) + sewd_pkg::WSUM_W'(i_sample);
        n_noise  = i_ctl.noise_en ? r_noise + sewd_pkg::NSUM_W'(i_sample) : r_noise;
        upd      = i_ctl.eval_en && (r_wsum > r_best);
        n_best   = upd ? r_wsum : r_best;
        n_bstart = upd ? i_ctl.start_idx : r_bstart;
    end

    // restoring divide step, one quotient bit a cycle
    assign div_tmp  = {r_rem, r_dvd_lo[sewd_pkg::SAMP_W-1]};
    assign div_ge   = div_tmp >= {1'b0, i_ctl.dead_zone};
    assign thr_prod = r_quot * i_ctl.thr_mult;

    // result for a closing beat
    always_comb begin
        base_idx     = (n_best == '0) ? sewd_pkg::OIDX_W'(i_ctl.dead_zone)
                                      : sewd_pkg::OIDX_W'(n_bstart);
        o_found      = i_ctl.n_ok && (n_best >= r_thr_p);
        o_echo_index = o_found ? base_idx + sewd_pkg::OIDX_W'(i_ctl.pulse >> 1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_ring[i_ctl.wr_ptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum   <= '0;
            r_best   <= '0;
            r_bstart <= '0;
            r_noise  <= '0;
            r_thr_p  <= '0;
        end else if (i_ctl.last) begin
            r_wsum   <= '0;
            r_best   <= '0;
            r_bstart <= '0;
            r_noise  <= '0;
            r_thr_p  <= '0;
        end else begin
            if (i_ctl.acc) begin
                r_wsum   <= n_wsum;
                r_best   <= n_best;
                r_bstart <= n_bstart;
                r_noise  <= n_noise;
            end
            if (i_ctl.do_scale) begin
                r_thr_p <= sewd_pkg::WSUM_W'(r_thr * i_ctl.pulse);
            end
        end
    end

    // noise floor divider and threshold scaling datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) begin
            r_rem    <= n_noise[sewd_pkg::NSUM_W-1:sewd_pkg::SAMP_W];
            r_dvd_lo <= n_noise[sewd_pkg::SAMP_W-1:0];
            r_quot   <= '0;
        end else if (i_ctl.div_step) begin
            r_rem    <= div_ge ? sewd_pkg::SAMP_W'(div_tmp - {1'b0, i_ctl.dead_zone})
                               : div_tmp[sewd_pkg::SAMP_W-1:0];
            r_dvd_lo <= {r_dvd_lo[sewd_pkg::SAMP_W-2:0], 1'b0};
            r_quot   <= {r_quot[sewd_pkg::SAMP_W-2:0], div_ge};
        end
        if (i_ctl.do_mult) begin
            r_thr <= (thr_prod > (2*sewd_pkg::SAMP_W)'(sewd_pkg::THR_SAT))
                     ? sewd_pkg::THR_SAT : thr_prod[sewd_pkg::SAMP_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sewd_merge.sv
// sewd_merge: gathers lane results into one output beat held until taken
`default_nettype none

module sewd_merge (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_load,
    input  wire logic [sewd_pkg::CHANNELS-1:0]      i_found,
    input  wire logic [sewd_pkg::OIDX_W-1:0]        i_echo_index [sewd_pkg::CHANNELS],
    input  wire logic                               i_m_tready,
    output logic                                    o_m_tvalid,
    output logic [sewd_pkg::OUT_TDATA_W-1:0]        o_m_tdata
);

    logic                              r_valid;
    logic [sewd_pkg::OUT_TDATA_W-1:0]  r_data;
    logic [sewd_pkg::OUT_TDATA_W-1:0]  n_data;

    always_comb begin
        n_data = '0;
        for (int ch = 0; ch < sewd_pkg::CHANNELS; ch++) begin
            n_data[ch*sewd_pkg::RES_W +: sewd_pkg::RES_W] = {i_echo_index[ch], i_found[ch]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

`default_nettype wire

FILE: test/sonar_echo_window_detector_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the four-lane sonar echo window detector

module sonar_echo_window_detector_top_test;

    localparam int NCH         = sewd_pkg::CHANNELS;
    // watchdog limit, with ample margin over the slowest correct run
    localparam int CYCLE_LIMIT = 400000;
    // quiet cycles after the last result before the registers are rewritten
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 400;

    // what one result beat carries, per receiver
    typedef struct packed {
        logic [NCH-1:0]                       found;
        logic [NCH-1:0][sewd_pkg::OIDX_W-1:0] index;
    } t_echo_report;

    typedef enum {CAP_ECHO, CAP_SHORT, CAP_NOISE, CAP_OVERLONG} t_capture_kind;

    // burst width as the block uses it: zero means one, capped at the ring depth
    function automatic int unsigned pulse_width_of(int unsigned plen);
        if (plen < 1) return 1;
        if (plen > sewd_pkg::MAX_PULSE) return sewd_pkg::MAX_PULSE;
        return plen;
    endfunction

    // ------------------------------------------------------------------
    // echo predictor and result store
    // ------------------------------------------------------------------
    class t_echo_scoreboard;
        int unsigned  dz, mult, plen;
        int unsigned  sample_total;
        logic [7:0]   ring [NCH][sewd_pkg::MAX_PULSE];
        int unsigned  win [NCH];
        int unsigned  best [NCH];
        int unsigned  best_at [NCH];
        int unsigned  noise [NCH];
        int unsigned  thr [NCH];
        t_echo_report expected_reports[$];
        int           mismatches;
        int           reports_seen;

        function new();
            dz   = sewd_pkg::DEAD_ZONE_RST;
            mult = sewd_pkg::THR_MULT_RST;
            plen = sewd_pkg::PULSE_LEN_RST;
            mismatches   = 0;
            reports_seen = 0;
            foreach (ring[c, k]) ring[c][k] = '0;
            clear_capture();
        endfunction

        function void clear_capture();
            sample_total = 0;
            foreach (win[c]) begin
                win[c]     = 0;
                best[c]    = 0;
                best_at[c] = 0;
                noise[c]   = 0;
                thr[c]     = 0;
            end
        endfunction

        function void write_register(logic [1:0] idx, logic [sewd_pkg::CFG_W-1:0] val);
            case (idx)
                sewd_pkg::REG_DEAD_ZONE: dz = val;
                sewd_pkg::REG_THR_MULT:  mult = val;
                sewd_pkg::REG_PULSE_LEN: plen = val[sewd_pkg::PLEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // one sample set accepted; a tlast beat closes the capture
        function void note_sample_set(logic [sewd_pkg::IN_TDATA_W-1:0] beat, logic closes);
            int unsigned  p, d, e, s, t, start;
            t_echo_report rep;
            p = pulse_width_of(plen);
            d = dz;
            e = sample_total;
            if (e < sewd_pkg::MAX_SAMPLES) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    s = beat[ch*sewd_pkg::SAMP_W +: sewd_pkg::SAMP_W];
                    // window that ended on the previous sample
                    if (e >= d + p && win[ch] > best[ch]) begin
                        best[ch]    = win[ch];
                        best_at[ch] = e - p;
                    end
                    if (e < d) noise[ch] += s;
                    if (e >= p) win[ch] -= ring[ch][(e - p) % sewd_pkg::MAX_PULSE];
                    win[ch] += s;
                    ring[ch][e % sewd_pkg::MAX_PULSE] = s[7:0];
                    if (d >= 1 && e == d - 1) begin
                        t = (noise[ch] / d) * mult;
                        thr[ch] = (t > 255) ? 255 : t;
                    end
                end
                sample_total = e + 1;
            end
            if (!closes) return;
            rep = '0;
            for (int ch = 0; ch < NCH; ch++) begin
                start = (best[ch] == 0) ? d : best_at[ch];
                if (sample_total >= d + p && best[ch] >= thr[ch] * p) begin
                    rep.found[ch] = 1'b1;
                    rep.index[ch] = sewd_pkg::OIDX_W'(start + p / 2);
                end
            end
            expected_reports.push_back(rep);
            clear_capture();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_report(logic [sewd_pkg::OUT_TDATA_W-1:0] beat);
            t_echo_report                want;
            logic                        got_found;
            logic [sewd_pkg::OIDX_W-1:0] got_idx;
            reports_seen++;
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          reports_seen));
                return;
            end
            want = expected_reports.pop_front();
            for (int ch = 0; ch < NCH; ch++) begin
                got_found = beat[ch*sewd_pkg::RES_W];
                got_idx   = beat[ch*sewd_pkg::RES_W + 1 +: sewd_pkg::OIDX_W];
                if (got_found !== want.found[ch])
                    report_mismatch($sformatf("result %0d found_ch%0d got %b want %b",
                                              reports_seen, ch, got_found, want.found[ch]));
                if (got_idx !== want.index[ch])
                    report_mismatch($sformatf("result %0d echo_index_ch%0d got %0d want %0d",
                                              reports_seen, ch, got_idx, want.index[ch]));
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // block and its signals
    // ------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [sewd_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [sewd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [1:0]                       cfg_index;
    logic [sewd_pkg::CFG_W-1:0]       cfg_data;

    t_echo_scoreboard sb;

    // generator's copy of the current settings
    int unsigned cfg_dz, cfg_mult, cfg_plen;
    // while set neither side idles, but for the one long result hold-off
    bit          calm;
    int          budget_items;
    int          cycle_count;

    sonar_echo_window_detector_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: ends a run that hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("** sonar_echo_window_detector_top: FAILED **");
        $finish;
    end

    // all handshakes are seen at the rising edge; result first, then the
    // sample set, so a tlast beat never meets its own result in one edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) sb.check_report(m_tdata);
            if (s_tvalid && s_tready) sb.note_sample_set(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, plus one long hold-off once results flow so
    // that a tlast beat finds the output slot full and the input stalls
    initial begin : result_sink
        int  hold_left;
        bit  long_hold_done;
        hold_left      = 0;
        long_hold_done = 0;
        m_tready       = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!long_hold_done && sb.reports_seen >= 6) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1;
            end
            if (hold_left > 0) begin
                m_tready  = 1'b0;
                hold_left--;
            end else if (calm || $urandom_range(0, 99) < 60) begin
                m_tready = 1'b1;
            end else begin
                m_tready  = 1'b0;
                hold_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // driving tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_beat(logic [sewd_pkg::IN_TDATA_W-1:0] data, logic closes);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tlast  = closes;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [sewd_pkg::CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic configure(int unsigned dz, int unsigned mult, int unsigned plen);
        write_reg(sewd_pkg::REG_DEAD_ZONE, dz[sewd_pkg::CFG_W-1:0]);
        write_reg(sewd_pkg::REG_THR_MULT, mult[sewd_pkg::CFG_W-1:0]);
        write_reg(sewd_pkg::REG_PULSE_LEN, {3'b000, plen[sewd_pkg::PLEN_W-1:0]});
        cfg_valid = 1'b0;
        cfg_dz    = dz;
        cfg_mult  = mult;
        cfg_plen  = plen;
    endtask

    // stop offering, let every result come out and the block settle
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // one capture of sample sets; echo captures put a noise floor, mostly low, in
    // the dead zone and a burst of pulse width after it, per receiver
    task automatic send_capture(t_capture_kind kind);
        int unsigned                      d, p, n, n_eff, v;
        int unsigned                      floor_lvl [NCH];
        int unsigned                      amp [NCH];
        int                               echo_at [NCH];
        int                               echo2_at [NCH];
        int                               shape [NCH];
        logic [sewd_pkg::IN_TDATA_W-1:0]  beat;
        bit                               hit;
        d = cfg_dz;
        p = pulse_width_of(cfg_plen);
        calm = ($urandom_range(0, 4) == 0);
        case (kind)
            CAP_ECHO:     n = d + p + $urandom_range(1, 12);
            CAP_OVERLONG: n = sewd_pkg::MAX_SAMPLES + $urandom_range(1, 8);
            CAP_SHORT:    n = (d + p > 1) ? $urandom_range(1, d + p - 1) : 1;
            default:      n = $urandom_range(1, d + p + 12);
        endcase
        n_eff = (n > sewd_pkg::MAX_SAMPLES) ? sewd_pkg::MAX_SAMPLES : n;
        for (int ch = 0; ch < NCH; ch++) begin
            floor_lvl[ch] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 25);
            amp[ch]       = $urandom_range(40, 255);
            // latest window that the block weighs starts at n_eff - p - 1
            echo_at[ch]   = (n_eff >= d + p + 1) ? $urandom_range(d, n_eff - p - 1) : d;
            // shape 0: plain echo, 1: silent receiver, 2: two equal echoes
            shape[ch]     = $urandom_range(0, 5);
            shape[ch]     = (shape[ch] > 2) ? 0 : shape[ch];
            echo2_at[ch]  = echo_at[ch] + p + $urandom_range(0, 3);
            if (shape[ch] != 2 || echo2_at[ch] + p + 1 > n_eff) echo2_at[ch] = -1000;
        end
        for (int i = 0; i < n; i++) begin
            for (int ch = 0; ch < NCH; ch++) begin
                hit = (i >= echo_at[ch] && i < echo_at[ch] + p) ||
                      (i >= echo2_at[ch] && i < echo2_at[ch] + p);
                if (kind == CAP_SHORT || kind == CAP_NOISE)
                    v = $urandom_range(0, 255);
                else if (shape[ch] == 1)
                    v = 0;
                else if (i < d)
                    v = floor_lvl[ch] + $urandom_range(0, 3);
                else if (hit)
                    v = amp[ch];
                else if (shape[ch] == 2)
                    v = 0;
                else
                    v = $urandom_range(0, floor_lvl[ch] / 2 + 2);
                beat[ch*sewd_pkg::SAMP_W +: sewd_pkg::SAMP_W] = (v > 255) ? 8'd255 : v[7:0];
            end
            send_beat(beat, i == n - 1);
            if (kind != CAP_OVERLONG) budget_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [sewd_pkg::IN_TDATA_W-1:0] beat;
        int                              r;
        sb           = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = sewd_pkg::REG_DEAD_ZONE;
        cfg_data     = '0;
        calm         = 0;
        budget_items = 0;
        cfg_dz       = sewd_pkg::DEAD_ZONE_RST;
        cfg_mult     = sewd_pkg::THR_MULT_RST;
        cfg_plen     = sewd_pkg::PULSE_LEN_RST;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed capture at the reset settings (dead zone 16, pulse 1):
        // ch0 quiet floor then a lone echo, ch1 silent so no positive window
        // with a zero threshold, ch2 full scale with a saturated threshold met
        // exactly, ch3 misses its threshold but for the final-sample window
        // which must never count
        for (int i = 0; i < 18; i++) begin
            beat[7:0]   = (i < 16) ? 8'(i % 2) : ((i == 16) ? 8'd200 : 8'd0);
            beat[15:8]  = 8'd0;
            beat[23:16] = 8'd255;
            beat[31:24] = (i < 16) ? 8'd20 : ((i == 16) ? 8'd50 : 8'd255);
            send_beat(beat, i == 17);
        end
        // capture of a single set, far too short
        send_beat({sewd_pkg::IN_TDATA_W{1'b1}}, 1'b1);

        // extremes of the registers, out-of-range pulse widths, zero dead zone
        wait_idle();
        configure(1, 0, 20);
        repeat (3) send_capture(CAP_ECHO);
        send_capture(CAP_SHORT);
        wait_idle();
        configure(0, 255, 0);
        repeat (2) send_capture(CAP_ECHO);
        send_capture(CAP_NOISE);
        wait_idle();
        configure(7, 255, 31);
        repeat (2) send_capture(CAP_ECHO);
        send_capture(CAP_SHORT);
        // widest dead zone and burst in one capture that overruns the limit
        wait_idle();
        configure(255, 1, 20);
        send_capture(CAP_OVERLONG);
        send_capture(CAP_SHORT);

        // random settings, mostly small so captures stay short
        while (budget_items < 550) begin
            wait_idle();
            r = $urandom_range(0, 9);
            configure((r == 0) ? 0 : ((r == 1) ? $urandom_range(11, 30)
                                                : $urandom_range(1, 10)),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(1, 8));
            repeat ($urandom_range(3, 6)) begin
                r = $urandom_range(0, 9);
                send_capture((r < 7) ? CAP_ECHO : ((r == 7) ? CAP_SHORT : CAP_NOISE));
            end
        end

        calm = 0;
        wait_idle();
        if (sb.mismatches == 0) begin
            $display("** sonar_echo_window_detector_top: PASSED **");
        end else begin
            $display("** sonar_echo_window_detector_top: FAILED **");
        end
        $finish;
    end

endmodule
